### hdl/srp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srp_pkg: shared types and codes for the skyline rectangle packer
// Status codes, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package srp_pkg;

   localparam int unsigned DIM_W   = 13;
   localparam int unsigned MAX_DIM = 4096;

   typedef logic [DIM_W-1:0] dim_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_NOFIT = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic REQ_CLEAR = 1'b0;
   localparam logic REQ_PLACE = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN,
      S_EVAL,
      S_LAST_RD,
      S_SPL_RD,
      S_SPL,
      S_COPY_RD,
      S_COPY,
      S_DONE,
      S_INIT
   } state_type;

endpackage
`default_nettype wire

### hdl/skyline_rect_packer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skyline_rect_packer_core: skyline bottom-left rectangle packer
// Keeps the skyline in a point memory, scans it for the lowest base and
// splices the placed rectangle into a second list, then copies it back.
// ----------------------------------------------------------------------------
// The scan walks the skyline with one point read per cycle; the block takes
// one request at a time.
// Reset (synchronous): the width and height registers go to MAX_DIM; busy
// stays high after reset while the empty skyline is written. Receiver cannot stall.
module skyline_rect_packer_core #(
   parameter int unsigned MAX_POINTS = 64
) (
   input  wire  logic                   clock,
   input  wire  logic                   reset,
   input  wire  logic                   start,
   output logic                         busy,
   input  wire  logic                   req_type,
   input  wire  srp_pkg::dim_type       req_width,
   input  wire  srp_pkg::dim_type       req_height,
   output logic                         rsp_strobe,
   output srp_pkg::status_type          rsp_status,
   output srp_pkg::dim_type             rsp_pos_x,
   output srp_pkg::dim_type             rsp_pos_y,
   input  wire  logic                   csr_write,
   input  wire  logic                   csr_index,
   input  wire  srp_pkg::dim_type       csr_data
);
   import srp_pkg::*;

   localparam int unsigned AW = $clog2(MAX_POINTS);
   localparam int unsigned CW = $clog2(MAX_POINTS + 3);
   localparam int unsigned SW = DIM_W + 1;
   localparam logic [CW-1:0] CAP = CW'(MAX_POINTS);

   // point memories: live skyline and scratch list
   logic [2*DIM_W-1:0] pt_mem [MAX_POINTS];
   logic [2*DIM_W-1:0] nx_mem [MAX_POINTS];
   logic [2*DIM_W-1:0] pt_rd_ff, nx_rd_ff;
   logic [AW-1:0]      pt_ra, nx_ra, pt_wa, nx_wa;
   logic               pt_we, nx_we;
   logic [2*DIM_W-1:0] pt_wd, nx_wd;

   always_ff @(posedge clock) begin
      if (pt_we) pt_mem[pt_wa] <= pt_wd;
      pt_rd_ff <= pt_mem[pt_ra];
   end
   always_ff @(posedge clock) begin
      if (nx_we) nx_mem[nx_wa] <= nx_wd;
      nx_rd_ff <= nx_mem[nx_ra];
   end

   dim_type rd_x, rd_y;
   assign rd_x = pt_rd_ff[2*DIM_W-1:DIM_W];
   assign rd_y = pt_rd_ff[DIM_W-1:0];

   // registers
   state_type  state_ff, state_in;
   dim_type    aw_ff, ah_ff, w_ff, h_ff;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, best_ff, best_in, nc_ff, nc_in;
   logic [CW-1:0] last_ff, last_in;
   dim_type    right_ff, right_in, base_ff, base_in, ix_ff, ix_in;
   dim_type    miny_ff, miny_in, rx_ff, rx_in, prevy_ff, prevy_in;
   dim_type    lx_ff, lx_in, ly_ff, ly_in;
   logic       found_ff, found_in, ph_ff, ph_in;
   status_type st_ff, st_in;
   logic       strobe_ff, strobe_in;
   dim_type    ox_ff, ox_in, oy_ff, oy_in;

   // saturated register write value
   dim_type csr_sat;
   always_comb begin
      if ({19'd0, csr_data} > MAX_DIM) csr_sat = DIM_W'(MAX_DIM);
      else csr_sat = csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aw_ff <= DIM_W'(MAX_DIM);
         ah_ff <= DIM_W'(MAX_DIM);
      end else if (csr_write) begin
         if (csr_index == REG_WIDTH) aw_ff <= csr_sat;
         else aw_ff <= aw_ff;
         if (csr_index == REG_HEIGHT) ah_ff <= csr_sat;
      end
   end

   // scratch push with merge against the previous kept height
   logic          push_v;
   dim_type       push_x, push_y;
   logic          push_ok;

   logic [SW-1:0] sum_right, sum_top;
   assign sum_right = {1'b0, rd_x} + {1'b0, w_ff};
   assign sum_top   = {1'b0, base_ff} + {1'b0, h_ff};

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      n_in = n_ff; i_in = i_ff; j_in = j_ff; best_in = best_ff; nc_in = nc_ff;
      last_in = last_ff; right_in = right_ff; base_in = base_ff; ix_in = ix_ff;
      miny_in = miny_ff; rx_in = rx_ff; prevy_in = prevy_ff; found_in = found_ff;
      lx_in = lx_ff; ly_in = ly_ff; ph_in = ph_ff;
      st_in = st_ff; ox_in = ox_ff; oy_in = oy_ff; strobe_in = 1'b0;
      pt_ra = '0; nx_ra = '0; pt_we = 1'b0; nx_we = 1'b0;
      pt_wa = '0; nx_wa = '0; pt_wd = '0; nx_wd = '0;
      push_v = 1'b0; push_x = '0; push_y = '0;
      case (state_ff)
         S_INIT: begin
            // empty skyline after reset, no result
            pt_we = 1'b1; pt_wa = '0; pt_wd = '0;
            nx_we = 1'b1; nx_wa = AW'(1); nx_wd = {aw_ff, {DIM_W{1'b0}}};
            n_in = CW'(2); i_in = CW'(1); nc_in = CW'(2); ph_in = 1'b0;
            state_in = S_COPY_RD;
         end
         S_IDLE: begin
            if (start) begin
               if (req_type == REQ_CLEAR) begin
                  pt_we = 1'b1; pt_wa = '0; pt_wd = '0;
                  nx_we = 1'b1; nx_wa = AW'(1); nx_wd = {aw_ff, {DIM_W{1'b0}}};
                  // entry 1 via copy of scratch: written to the scratch list above
                  n_in = CW'(2);
                  st_in = ST_OK; ox_in = '0; oy_in = '0;
                  i_in = CW'(1); nc_in = CW'(2); ph_in = 1'b1;
                  state_in = S_COPY_RD;
               end else begin
                  i_in = '0; found_in = 1'b0; miny_in = ah_ff; best_in = '0;
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            if (i_ff + CW'(1) >= n_ff) state_in = S_EVAL;
            else begin
               pt_ra = AW'(i_ff); j_in = i_ff + CW'(1); ph_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // ph 0: start point data; then span points
            if (!ph_ff) begin
               if (sum_right > {1'b0, aw_ff}) state_in = S_EVAL;
               else begin
                  right_in = sum_right[DIM_W-1:0]; base_in = rd_y; ix_in = rd_x;
                  ph_in = 1'b1;
                  if (j_ff < n_ff) pt_ra = AW'(j_ff);
                  else state_in = S_LAST_RD;
               end
            end else begin
               if (rd_x >= right_ff) state_in = S_LAST_RD;
               else begin
                  if (rd_y > base_ff) base_in = rd_y;
                  j_in = j_ff + CW'(1);
                  if (j_ff + CW'(1) < n_ff) pt_ra = AW'(j_ff + CW'(1));
                  else state_in = S_LAST_RD;
               end
            end
         end
         S_LAST_RD: begin
            // base for position i is final
            if (sum_top > {1'b0, ah_ff}) state_in = S_EVAL;
            else begin
               if (base_ff < miny_ff) begin
                  best_in = i_ff; miny_in = base_ff; found_in = 1'b1;
                  rx_in = ix_ff;
               end
               i_in = i_ff + CW'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_EVAL: begin
            if (!found_ff) begin
               st_in = ST_NOFIT; ox_in = '0; oy_in = '0; state_in = S_DONE;
            end else begin
               j_in = '0; nc_in = '0; ph_in = 1'b0; last_in = best_ff;
               right_in = rx_ff + w_ff;
               pt_ra = '0; state_in = S_SPL;
            end
         end
         S_SPL_RD: begin
            pt_ra = AW'(j_ff); state_in = S_SPL;
         end
         S_SPL: begin
            // splice: j walks the old list, rd holds point j
            if (j_ff + CW'(1) >= n_ff) begin
               // last point: kept without merge
               if (ph_ff == 1'b0) begin
                  push_v = 1'b1; push_x = rx_ff; push_y = miny_ff + h_ff;
                  ph_in = 1'b1; state_in = S_SPL;
                  pt_ra = AW'(j_ff);
               end else if (lx_ff != right_ff || ly_ff != miny_ff ||
                            last_ff != CW'(MAX_POINTS + 2)) begin
                  push_v = 1'b1; push_x = right_ff; push_y = miny_ff;
                  last_in = CW'(MAX_POINTS + 2); lx_in = right_ff; ly_in = miny_ff;
                  pt_ra = AW'(j_ff);
               end else begin
                  if (nc_ff >= CAP) begin
                     st_in = ST_FULL; ox_in = '0; oy_in = '0; state_in = S_DONE;
                  end else begin
                     nx_we = 1'b1; nx_wa = AW'(nc_ff); nx_wd = pt_rd_ff;
                     n_in = nc_ff + CW'(1); nc_in = nc_ff + CW'(1);
                     st_in = ST_OK; ox_in = rx_ff; oy_in = miny_ff;
                     i_in = '0; state_in = S_COPY_RD;
                  end
               end
            end else if (j_ff < best_ff) begin
               push_v = 1'b1; push_x = rd_x; push_y = rd_y;
               j_in = j_ff + CW'(1); state_in = S_SPL_RD;
            end else if (ph_ff == 1'b0) begin
               push_v = 1'b1; push_x = rx_ff; push_y = miny_ff + h_ff;
               ph_in = 1'b1; pt_ra = AW'(j_ff);
            end else if (last_ff != CW'(MAX_POINTS + 2)) begin
               // skip covered points, then push the right end point
               if (rd_x < right_ff && j_ff != best_ff) begin
                  j_in = j_ff + CW'(1); state_in = S_SPL_RD;
               end else if (j_ff == best_ff) begin
                  j_in = j_ff + CW'(1); state_in = S_SPL_RD;
               end else begin
                  push_v = 1'b1; push_x = right_ff; push_y = miny_ff;
                  last_in = CW'(MAX_POINTS + 2); lx_in = right_ff; ly_in = miny_ff;
                  pt_ra = AW'(j_ff);
               end
            end else begin
               push_v = 1'b1; push_x = rd_x; push_y = rd_y;
               j_in = j_ff + CW'(1); state_in = S_SPL_RD;
            end
         end
         S_COPY_RD: begin
            // the init pass after reset ends without a result
            if (i_ff >= nc_ff) state_in = ph_ff ? S_DONE : S_IDLE;
            else begin
               nx_ra = AW'(i_ff); state_in = S_COPY;
            end
         end
         S_COPY: begin
            pt_we = 1'b1; pt_wa = AW'(i_ff); pt_wd = nx_rd_ff;
            i_in = i_ff + CW'(1); state_in = S_COPY_RD;
         end
         S_DONE: begin
            strobe_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      push_ok = push_v && !(nc_ff != '0 && prevy_ff == push_y)
                && (nc_ff < CW'(MAX_POINTS));
      if (push_ok) begin
         nx_we = 1'b1; nx_wa = AW'(nc_ff); nx_wd = {push_x, push_y};
         nc_in = nc_ff + CW'(1); prevy_in = push_y;
      end else if (push_v && nc_ff >= CW'(MAX_POINTS) &&
                   !(nc_ff != '0 && prevy_ff == push_y)) begin
         nc_in = CAP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; strobe_ff <= 1'b0; n_ff <= CW'(2);
      end else begin
         state_ff <= state_in; strobe_ff <= strobe_in; n_ff <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in; j_ff <= j_in; best_ff <= best_in; nc_ff <= nc_in;
      last_ff <= last_in; right_ff <= right_in; base_ff <= base_in; ix_ff <= ix_in;
      miny_ff <= miny_in; rx_ff <= rx_in; prevy_ff <= prevy_in;
      found_ff <= found_in; ph_ff <= ph_in; lx_ff <= lx_in; ly_ff <= ly_in;
      st_ff <= st_in; ox_ff <= ox_in; oy_ff <= oy_in;
      if (state_ff == S_IDLE && start) begin
         w_ff <= req_width; h_ff <= req_height;
      end
   end

   assign busy       = (state_ff != S_IDLE) || reset;
   assign rsp_strobe = strobe_ff;
   assign rsp_status = st_ff;
   assign rsp_pos_x  = ox_ff;
   assign rsp_pos_y  = oy_ff;

   // checks
   a_cnt_min: assert property (@(posedge clock) disable iff (reset)
      n_ff >= CW'(2)) else $error("point count below two");
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe longer than one cycle");
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |-> rsp_pos_x == '0 && rsp_pos_y == '0)
      else $error("position set on a refused request");
endmodule
`default_nettype wire

### sim/tb_skyline_rect_packer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_skyline_rect_packer_core: self-checking bench for the skyline packer
// Drives clear and place words through the start/busy handshake. A local
// skyline model predicts status and position for each word, and a monitor
// compares every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_skyline_rect_packer_core;
   import srp_pkg::*;

   localparam int unsigned MAXP = 64;
   localparam int unsigned MAXD = 4096;
   localparam int unsigned WDOG_LIMIT = 200000;

   typedef struct packed {
      status_type status;
      dim_type    pos_x;
      dim_type    pos_y;
   } placement_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic       req_type;
   dim_type    req_width;
   dim_type    req_height;
   logic       rsp_strobe;
   status_type rsp_status;
   dim_type    rsp_pos_x;
   dim_type    rsp_pos_y;
   logic       csr_write;
   logic       csr_index;
   dim_type    csr_data;

   // predictor state
   int unsigned   sky_x[MAXP];
   int unsigned   sky_y[MAXP];
   int unsigned   sky_n;
   int unsigned   atlas_w;
   int unsigned   atlas_h;
   placement_type expected_q[$];
   int unsigned   error_count;
   int unsigned   wdog = 0;
   int unsigned   n_place;
   int unsigned   n_nofit;
   int unsigned   n_full;
   int unsigned   n_clear;

   skyline_rect_packer_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_width(req_width), .req_height(req_height),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int unsigned sat_dim(int unsigned v);
      return (v > MAXD) ? MAXD : v;
   endfunction

   function automatic void clear_sky();
      for (int k = 0; k < MAXP; k++) begin
         sky_x[k] = 0;
         sky_y[k] = 0;
      end
      sky_x[1] = atlas_w;
      sky_n = 2;
   endfunction

   // bottom-left search and splice on the local skyline
   function automatic placement_type place_rect(logic rtype, int unsigned w,
                                                int unsigned h);
      placement_type r;
      int unsigned nx[MAXP+2];
      int unsigned ny[MAXP+2];
      int unsigned nn, best, min_y, right, base, last, x_end;
      bit found;
      r.status = ST_OK;
      r.pos_x = '0;
      r.pos_y = '0;
      if (rtype == REQ_CLEAR) begin
         clear_sky();
         n_clear++;
         return r;
      end
      best = 0;
      min_y = atlas_h;
      found = 0;
      for (int i = 0; i + 1 < sky_n; i++) begin
         right = sky_x[i] + w;
         base = sky_y[i];
         if (right > atlas_w) break;
         for (int j = i + 1; j < sky_n; j++) begin
            if (sky_x[j] >= right) break;
            if (sky_y[j] > base) base = sky_y[j];
         end
         if (base + h > atlas_h) break;
         if (base < min_y) begin
            best = i;
            min_y = base;
            found = 1;
         end
      end
      if (!found) begin
         r.status = ST_NOFIT;
         n_nofit++;
         return r;
      end
      nn = 0;
      x_end = sky_x[best] + w;
      last = best;
      for (int j = 0; j < best; j++) begin
         if (!(nn > 0 && ny[nn-1] == sky_y[j])) begin
            nx[nn] = sky_x[j]; ny[nn] = sky_y[j]; nn++;
         end
      end
      if (!(nn > 0 && ny[nn-1] == min_y + h)) begin
         nx[nn] = sky_x[best]; ny[nn] = min_y + h; nn++;
      end
      for (int j = best; j + 1 < sky_n; j++) begin
         if (sky_x[j] >= x_end) break;
         last = j;
      end
      if (!(nn > 0 && ny[nn-1] == min_y)) begin
         nx[nn] = x_end; ny[nn] = min_y; nn++;
      end
      for (int j = last + 1; j + 1 < sky_n; j++) begin
         if (!(nn > 0 && ny[nn-1] == sky_y[j]) && nn < MAXP + 2) begin
            nx[nn] = sky_x[j]; ny[nn] = sky_y[j]; nn++;
         end
      end
      if (nn >= MAXP) begin
         r.status = ST_FULL;
         n_full++;
         return r;
      end
      nx[nn] = sky_x[sky_n-1];
      ny[nn] = sky_y[sky_n-1];
      nn++;
      r.pos_x = dim_type'(sky_x[best]);
      r.pos_y = dim_type'(min_y);
      for (int k = 0; k < nn; k++) begin
         sky_x[k] = nx[k];
         sky_y[k] = ny[k];
      end
      sky_n = nn;
      n_place++;
      return r;
   endfunction

   // mostly short gaps, a few long ones, some back to back
   task automatic idle_gap();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 40) return;
      start <= 1'b0;
      if (sel < 92) repeat ($urandom_range(1, 3)) @(posedge clock);
      else repeat ($urandom_range(10, 40)) @(posedge clock);
   endtask

   // send one word and queue its prediction
   task automatic send_word(logic rtype, int unsigned w, int unsigned h);
      start      <= 1'b1;
      req_type   <= rtype;
      req_width  <= dim_type'(w);
      req_height <= dim_type'(h);
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_q.push_back(place_rect(rtype, w & 13'h1FFF, h & 13'h1FFF));
      idle_gap();
   endtask

   // wait for every result, then the block's settle time
   task automatic drain();
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, int unsigned val);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= dim_type'(val);
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == REG_WIDTH) atlas_w = sat_dim(val & 13'h1FFF);
      else atlas_h = sat_dim(val & 13'h1FFF);
   endtask

   // random size: mostly small, sometimes anything the field holds
   function automatic int unsigned rand_dim(int unsigned lim);
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 5) return 0;
      if (sel < 10) return $urandom_range(0, 8191);
      if (sel < 15) return lim;
      return $urandom_range(1, (lim / 8 > 1) ? lim / 8 : 1);
   endfunction

   task automatic test_directed();
      send_word(REQ_PLACE, 0, 0);
      send_word(REQ_PLACE, 4096, 1);
      send_word(REQ_PLACE, 1, 4096);
      send_word(REQ_CLEAR, 8191, 8191);
      send_word(REQ_PLACE, 4096, 4096);
      send_word(REQ_PLACE, 1, 1);
      send_word(REQ_PLACE, 8191, 1);
      send_word(REQ_PLACE, 1, 8191);
      send_word(REQ_CLEAR, 0, 0);
      send_word(REQ_PLACE, 100, 50);
      send_word(REQ_PLACE, 100, 50);
      send_word(REQ_PLACE, 50, 20);
      send_word(REQ_PLACE, 4000, 10);
      send_word(REQ_PLACE, 10, 0);
      send_word(REQ_PLACE, 0, 4095);
      send_word(REQ_CLEAR, 0, 0);
   endtask

   // registers: extremes, saturation, zero, and change without clear
   task automatic test_registers();
      write_reg(REG_WIDTH, 8191);
      write_reg(REG_HEIGHT, 5000);
      send_word(REQ_PLACE, 4096, 1);
      send_word(REQ_CLEAR, 0, 0);
      write_reg(REG_WIDTH, 0);
      write_reg(REG_HEIGHT, 1);
      send_word(REQ_PLACE, 1, 1);
      send_word(REQ_CLEAR, 0, 0);
      send_word(REQ_PLACE, 0, 1);
      send_word(REQ_PLACE, 0, 0);
      send_word(REQ_PLACE, 1, 0);
      write_reg(REG_WIDTH, 1);
      write_reg(REG_HEIGHT, 0);
      send_word(REQ_CLEAR, 0, 0);
      send_word(REQ_PLACE, 1, 0);
      send_word(REQ_PLACE, 1, 1);
   endtask

   // fill the point store with narrow columns of varied height
   task automatic test_store_full();
      write_reg(REG_WIDTH, 4096);
      write_reg(REG_HEIGHT, 4096);
      send_word(REQ_CLEAR, 0, 0);
      for (int k = 0; k < 80; k++) send_word(REQ_PLACE, 3, (k % 2) ? 1 : 2 + k);
   endtask

   task automatic test_random();
      int unsigned sizes_w[4] = '{4096, 64, 300, 1};
      int unsigned sizes_h[4] = '{4096, 200, 64, 4096};
      for (int ph = 0; ph < 8; ph++) begin
         if (ph < 4) begin
            write_reg(REG_WIDTH, sizes_w[ph]);
            write_reg(REG_HEIGHT, sizes_h[ph]);
         end else begin
            write_reg(REG_WIDTH, $urandom_range(1, 4096));
            write_reg(REG_HEIGHT, $urandom_range(1, 4096));
         end
         send_word(REQ_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 8191));
         for (int k = 0; k < 150; k++) begin
            if ($urandom_range(0, 99) < 3)
               send_word(REQ_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 8191));
            else
               send_word(REQ_PLACE, rand_dim(atlas_w), rand_dim(atlas_h));
         end
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      placement_type exp_r;
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result status=%0d x=%0d y=%0d", $time,
                     rsp_status, rsp_pos_x, rsp_pos_y);
            error_count++;
         end else begin
            exp_r = expected_q.pop_front();
            if (rsp_status !== exp_r.status || rsp_pos_x !== exp_r.pos_x ||
                rsp_pos_y !== exp_r.pos_y) begin
               $display("%0t: mismatch expected status=%0d x=%0d y=%0d, got %0d %0d %0d",
                        $time, exp_r.status, exp_r.pos_x, exp_r.pos_y,
                        rsp_status, rsp_pos_x, rsp_pos_y);
               error_count++;
            end
         end
      end
   end

   // watchdog: cycles without a handshake or result
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy) || csr_write) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      n_place = 0; n_nofit = 0; n_full = 0; n_clear = 0;
      atlas_w = MAXD;
      atlas_h = MAXD;
      clear_sky();
      reset = 1'b1;
      start = 1'b0;
      req_type = REQ_CLEAR;
      req_width = '0;
      req_height = '0;
      csr_write = 1'b0;
      csr_index = REG_WIDTH;
      csr_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_registers();
      test_store_full();
      test_random();
      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d placed, %0d no-fit, %0d store-full, %0d clear words",
               n_place, n_nofit, n_full, n_clear);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
